// ===== src/rtd_pkg.sv =====
// shared types and constants for the rtd resistance / temperature converter
// no dependencies
package rtd_pkg;

  // curve coefficients
  localparam logic [31:0] RES_SLOPE_K  = 32'd1240;
  localparam logic [31:0] RES_OFFSET_K = 32'd273709676;
  localparam logic [31:0] DER_SLOPE_K  = 32'd2480;
  localparam logic [31:0] DER_OFFSET_K = 32'd273672960;
  localparam logic [15:0] R0_SCALED    = 16'd8192;

  // mode codes
  localparam logic MODE_R2T = 1'b0;
  localparam logic MODE_T2R = 1'b1;

  // divider width and per-step pipeline depth
  localparam int DIV_BITS = 32;
  localparam int STEP_LAT = 4 + 1 + DIV_BITS + 1;

  localparam int NEWTON_STEPS_DEF = 2;

  // word traveling through the pipeline
  typedef struct packed {
    logic               mode;
    logic signed [15:0] rm;
    logic signed [15:0] t;
    logic        [15:0] res;
  } token_t;

endpackage

// ===== src/rtd_resistance_temperature_convert_top.sv =====
// top level of the rtd resistance / temperature converter
// depends on rtd_pkg and rtd_step
//
// usage:
//   a word is taken when start is high and busy is low; busy is always low,
//   so one word can enter on every clock. in_mode 0 converts a scaled
//   resistance (8192 = R0) in in_sample_value to temperature through
//   NEWTON_STEPS newton steps; in_mode 1 converts a scaled temperature to
//   resistance.
//   each word gives one result on out_temperature_out / out_resistance_out,
//   marked by out_valid for exactly one cycle; the field not used by the
//   mode reads zero.
//   each newton step has 4 curve stages, one divider prep stage, 32 one-bit
//   divider stages and one update stage, then a result register; throughput
//   is one word per cycle, set by the fully pipelined divider.
//   results come out in order; the receiver cannot stall, so nothing queues.
//   synchronous reset clears all valid bits and drops words in flight.
module rtd_resistance_temperature_convert_top #(
  parameter int NEWTON_STEPS = rtd_pkg::NEWTON_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [15:0] in_sample_value,
  output logic               out_valid,
  output logic signed [15:0] out_temperature_out,
  output logic        [15:0] out_resistance_out
);

  localparam int LAT = NEWTON_STEPS * rtd_pkg::STEP_LAT + 1;

  logic            sv  [0:NEWTON_STEPS];
  rtd_pkg::token_t stk [0:NEWTON_STEPS];

  assign busy = 1'b0;

  // entry word with initial guess
  always_comb begin
    sv[0]      = start & ~busy;
    stk[0].mode = in_mode;
    stk[0].rm   = in_sample_value;
    stk[0].t    = (in_mode == rtd_pkg::MODE_T2R) ? in_sample_value
                                                : in_sample_value - 16'sd8192;
    stk[0].res  = '0;
  end

  // chain of newton steps
  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
    rtd_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sv[i]),
      .in_tok    (stk[i]),
      .out_valid (sv[i+1]),
      .out_tok   (stk[i+1])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv[NEWTON_STEPS];
    end
    if (stk[NEWTON_STEPS].mode == rtd_pkg::MODE_T2R) begin
      out_temperature_out <= '0;
      out_resistance_out  <= stk[NEWTON_STEPS].res;
    end else begin
      out_temperature_out <= stk[NEWTON_STEPS].t;
      out_resistance_out  <= '0;
    end
  end

`ifndef NO_ASSERTIONS
  // every result traces back to an input word taken earlier
  a_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching input word");

  // only one result field is live
  a_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_out == '0 || out_resistance_out == '0))
    else $error("both result fields nonzero");
`endif

endmodule

// ===== src/rtd_div.sv =====
// pipelined signed 32 / unsigned 16 divider, one quotient bit per stage
// depends on rtd_pkg
module rtd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rtd_pkg::token_t     in_tok,
  input  logic signed [31:0]  num,
  input  logic        [15:0]  den,
  output logic                out_valid,
  output rtd_pkg::token_t     out_tok,
  output logic        [31:0]  quo
);

  localparam int N = rtd_pkg::DIV_BITS;

  logic            v_r   [0:N];
  rtd_pkg::token_t tok_r [0:N];
  logic            neg_r [0:N];
  logic [15:0]     den_r [0:N];
  logic [15:0]     rem_r [0:N];
  logic [31:0]     nq_r  [0:N];

  // prep stage: magnitude and sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    tok_r[0] <= in_tok;
    neg_r[0] <= num[31];
    den_r[0] <= den;
    rem_r[0] <= '0;
    nq_r[0]  <= num[31] ? (32'd0 - num) : num;
  end

  // one restoring step per stage
  for (genvar k = 1; k <= N; k++) begin : g_bit
    logic [16:0] trial;
    logic        fits;
    assign trial = {rem_r[k-1], nq_r[k-1][31]};
    assign fits  = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
      tok_r[k] <= tok_r[k-1];
      neg_r[k] <= neg_r[k-1];
      den_r[k] <= den_r[k-1];
      rem_r[k] <= fits ? 16'(trial - {1'b0, den_r[k-1]}) : trial[15:0];
      nq_r[k]  <= {nq_r[k-1][30:0], fits};
    end
  end

  // sign fix, zero divisor gives zero
  always_comb begin
    if (den_r[N] == '0) begin
      quo = '0;
    end else if (neg_r[N]) begin
      quo = 32'd0 - nq_r[N];
    end else begin
      quo = nq_r[N];
    end
  end

  assign out_valid = v_r[N];
  assign out_tok   = tok_r[N];

endmodule

// ===== src/rtd_step.sv =====
// one newton refinement step: curve, slope, numerator, divide, update
// depends on rtd_pkg and rtd_div
module rtd_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  rtd_pkg::token_t in_tok,
  output logic            out_valid,
  output rtd_pkg::token_t out_tok
);

  logic            v1_r, v2_r, v3_r, v4_r;
  rtd_pkg::token_t t1_r, t2_r, t3_r, t4_r;
  logic [31:0]     p1_r, p2_r;
  logic [19:0]     u_r;
  logic [15:0]     sl2_r, sl3_r, sl4_r;
  logic [31:0]     m_r;
  logic signed [31:0] num_r;

  logic [31:0] t32;
  logic [31:0] a2, s2;
  logic [15:0] rcur;
  logic [31:0] diff;

  assign t32 = {{16{in_tok.t[15]}}, in_tok.t};

  // stage 1: constant products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    t1_r <= in_tok;
    p1_r <= rtd_pkg::RES_SLOPE_K * t32;
    p2_r <= rtd_pkg::DER_SLOPE_K * t32;
  end

  // stage 2: curve term and slope
  assign a2 = rtd_pkg::RES_OFFSET_K - p1_r;
  assign s2 = rtd_pkg::DER_OFFSET_K - p2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    t2_r  <= t1_r;
    u_r   <= a2[31:12];
    sl2_r <= s2[31:16];
  end

  // stage 3: curve term times t
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    t3_r  <= t2_r;
    sl3_r <= sl2_r;
    m_r   <= {12'd0, u_r} * {{16{t2_r.t[15]}}, t2_r.t};
  end

  // stage 4: resistance and newton numerator
  assign rcur = m_r[31:16] + rtd_pkg::R0_SCALED;
  assign diff = {16'd0, rcur} - {{16{t3_r.rm[15]}}, t3_r.rm};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    t4_r <= t3_r;
    if (t3_r.mode == rtd_pkg::MODE_T2R) begin
      t4_r.res <= rcur;
    end
    sl4_r <= sl3_r;
    num_r <= {diff[19:0], 12'd0};
  end

  logic            dv;
  rtd_pkg::token_t dtok;
  logic [31:0]     quo;

  rtd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_tok    (t4_r),
    .num       (num_r),
    .den       (sl4_r),
    .out_valid (dv),
    .out_tok   (dtok),
    .quo       (quo)
  );

  // update t in resistance mode only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv;
    end
    out_tok <= dtok;
    if (dtok.mode == rtd_pkg::MODE_R2T) begin
      out_tok.t <= dtok.t - quo[15:0];
    end
  end

endmodule
